// ----- rtl/stack_machine_executor_assert.svh -----
// Assertion helpers used by the RTL; each expects clk and rst_n in scope.
`ifndef STACK_MACHINE_EXECUTOR_ASSERT_SVH
`define STACK_MACHINE_EXECUTOR_ASSERT_SVH

// Same-cycle implication.
`define SME_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SME_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sme_pkg.sv -----
package sme_pkg;

    localparam logic [3:0] OP_END  = 4'h0;
    localparam logic [3:0] OP_PUSH = 4'h1;
    localparam logic [3:0] OP_POP  = 4'h2;
    localparam logic [3:0] OP_ADD  = 4'h3;
    localparam logic [3:0] OP_SUB  = 4'h4;
    localparam logic [3:0] OP_MUL  = 4'h5;
    localparam logic [3:0] OP_DIV  = 4'h6;
    localparam logic [3:0] OP_SQRT = 4'h7;
    localparam logic [3:0] OP_POW  = 4'h8;
    localparam logic [3:0] OP_SIN  = 4'h9;
    localparam logic [3:0] OP_COS  = 4'hA;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_END = 2'd1;
    localparam logic [1:0] ST_ERR = 2'd2;

    typedef struct packed {
        logic [3:0]         req_type;
        logic               push_from_acc;
        logic               pop_discard;
        logic signed [31:0] immediate;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] acc_value;
        logic signed [31:0] top_value;
        logic [4:0]         depth_used;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic shift_dn;
        logic shift_up;
    } cell_ctrl_t;

endpackage

// ----- rtl/sme_cell.sv -----
module sme_cell (
    input  logic               clk,
    input  sme_pkg::cell_ctrl_t ctrl,
    input  logic [31:0]        ins_val,
    input  logic [31:0]        below_val,
    output logic [31:0]        val
);
    import sme_pkg::*;

    logic [31:0] val_reg;
    logic [31:0] val_next;

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.load || ctrl.shift_dn)
        begin
            val_next = ins_val;
        end
        else if (ctrl.shift_up)
        begin
            val_next = below_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

// ----- rtl/sme_alu.sv -----
module sme_alu (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [3:0]  op,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [31:0] result,
    output logic        err
);
    import sme_pkg::*;

    localparam logic [1:0] AS_IDLE = 2'd0;
    localparam logic [1:0] AS_DIV  = 2'd1;
    localparam logic [1:0] AS_SQRT = 2'd2;
    localparam logic [1:0] AS_POW  = 2'd3;

    localparam logic [32:0] POW_LIMIT = 33'h0_8000_0000;
    localparam logic [32:0] POW_SAT   = 33'h0_8000_0001;

    logic [1:0]  state_reg, state_next;
    logic        done_reg, done_next;
    logic [31:0] res_reg, res_next;
    logic        err_reg, err_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic [31:0] root_reg, root_next;
    logic [31:0] bit_reg, bit_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] e_reg, e_next;

    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [32:0] rem_s;
    logic [31:0] trial;
    logic [63:0] prod;

    assign mag_a = a[31] ? (32'd0 - a) : a;
    assign mag_b = b[31] ? (32'd0 - b) : b;
    assign rem_s = {rem_reg[31:0], quo_reg[31]};
    assign trial = root_reg + bit_reg;
    assign prod  = {32'd0, r_reg[31:0]} * {32'd0, dvs_reg};

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        err_next   = err_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        r_next     = r_reg;
        e_next     = e_reg;
        unique case (state_reg)
            AS_IDLE:
            begin
                if (start)
                begin
                    err_next  = 1'b0;
                    done_next = 1'b1;
                    res_next  = 32'd0;
                    case (op)
                        OP_ADD: res_next = a + b;
                        OP_SUB: res_next = a - b;
                        OP_MUL: res_next = a * b;
                        OP_COS: res_next = (b == 32'd0) ? 32'd1 : 32'd0;
                        OP_DIV:
                        begin
                            if (b == 32'd0)
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                rem_next   = 33'd0;
                                quo_next   = mag_a;
                                dvs_next   = mag_b;
                                cnt_next   = 6'd0;
                                neg_next   = a[31] ^ b[31];
                                state_next = AS_DIV;
                            end
                        end
                        OP_SQRT:
                        begin
                            if (b[31])
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                quo_next   = b;
                                root_next  = 32'd0;
                                bit_next   = 32'h4000_0000;
                                state_next = AS_SQRT;
                            end
                        end
                        OP_POW:
                        begin
                            if (b == 32'd0)
                            begin
                                res_next = 32'd1;
                            end
                            else if (b[31])
                            begin
                                if (mag_a == 32'd0)
                                begin
                                    err_next = 1'b1;
                                end
                                else if (mag_a == 32'd1)
                                begin
                                    res_next = (a[31] && b[0]) ? 32'hFFFF_FFFF : 32'd1;
                                end
                            end
                            else
                            begin
                                // base of zero or one needs no multiply
                                done_next  = 1'b0;
                                r_next     = (mag_a == 32'd0) ? 33'd0 : 33'd1;
                                e_next     = (mag_a <= 32'd1) ? 32'd0 : b;
                                dvs_next   = mag_a;
                                neg_next   = a[31] && b[0];
                                state_next = AS_POW;
                            end
                        end
                        default: res_next = 32'd0;
                    endcase
                end
            end
            AS_DIV:
            begin
                if (cnt_reg == 6'd32)
                begin
                    res_next   = neg_reg ? (32'd0 - quo_reg) : quo_reg;
                    done_next  = 1'b1;
                    state_next = AS_IDLE;
                end
                else
                begin
                    if (rem_s >= {1'b0, dvs_reg})
                    begin
                        rem_next = rem_s - {1'b0, dvs_reg};
                        quo_next = {quo_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_s;
                        quo_next = {quo_reg[30:0], 1'b0};
                    end
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            AS_SQRT:
            begin
                if (bit_reg == 32'd0)
                begin
                    res_next   = root_reg;
                    done_next  = 1'b1;
                    state_next = AS_IDLE;
                end
                else
                begin
                    if (quo_reg >= trial)
                    begin
                        quo_next  = quo_reg - trial;
                        root_next = (root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_next = root_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
            end
            AS_POW:
            begin
                if (e_reg != 32'd0 && r_reg <= POW_LIMIT)
                begin
                    r_next = (prod > {31'd0, POW_LIMIT}) ? POW_SAT : prod[32:0];
                    e_next = e_reg - 32'd1;
                end
                else
                begin
                    if (neg_reg)
                    begin
                        res_next = (r_reg >= POW_LIMIT) ? 32'h8000_0000
                                                        : (32'd0 - r_reg[31:0]);
                    end
                    else
                    begin
                        res_next = (r_reg > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : r_reg[31:0];
                    end
                    done_next  = 1'b1;
                    state_next = AS_IDLE;
                end
            end
            default: state_next = AS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        err_reg  <= err_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        r_reg    <= r_next;
        e_reg    <= e_next;
    end

    assign done   = done_reg;
    assign result = res_reg;
    assign err    = err_reg;

endmodule

// ----- rtl/stack_machine_executor.sv -----
// Stack machine executor: takes one decoded instruction per req transaction and returns one
// rsp transaction with status, accumulator, top of stack and depth. The operand stack is a
// row of STACK_DEPTH register cells that shift as one on push and pop, so the top two
// entries are always at fixed cells. Instructions are handled one at a time. End, push,
// pop and stack errors go from accept straight to the commit state; the arithmetic ops
// otherwise wait first in the busy state for the shared arithmetic unit, with its
// bit-serial divider, two-bits-per-cycle root loop and repeated multiply for power. A
// new instruction is taken while the previous result still waits on a stalled rsp.
`include "stack_machine_executor_assert.svh"

module stack_machine_executor #(
    parameter int STACK_DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  sme_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output sme_pkg::rsp_t  rsp
);
    import sme_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_BUSY   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   acc_reg, acc_next;
    req_t          op_reg, op_next;
    logic          derr_reg, derr_next;
    logic          used_reg, used_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg, rsp_next;

    logic [31:0]   cell_val [STACK_DEPTH];
    logic [31:0]   ins_w    [STACK_DEPTH];
    logic [31:0]   blw_w    [STACK_DEPTH];
    cell_ctrl_t    ctrl_w   [STACK_DEPTH];
    cell_ctrl_t    top_ctrl, rest_ctrl;
    logic [31:0]   ins_val;

    logic          accept;
    logic          out_free;
    logic          commit_fire;
    logic          is_bin, is_una;
    logic          req_derr;
    logic          alu_start;
    logic          alu_done, alu_err;
    logic [31:0]   alu_res;
    logic          op_bin, op_una, fail;
    logic [31:0]   new_top;
    logic [31:0]   ext_depth;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        is_bin = 1'b0;
        is_una = 1'b0;
        case (req.req_type) inside
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW: is_bin = 1'b1;
            OP_SQRT, OP_SIN, OP_COS:                is_una = 1'b1;
            default:                                is_bin = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (req.req_type)
            OP_END:  req_derr = 1'b0;
            OP_PUSH: req_derr = (count_reg == CW'(STACK_DEPTH));
            OP_POP:  req_derr = (count_reg == CW'(0));
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW:
                     req_derr = (count_reg < CW'(2));
            OP_SQRT, OP_SIN, OP_COS:
                     req_derr = (count_reg == CW'(0));
            default: req_derr = 1'b1;
        endcase
    end

    assign alu_start = accept && (is_bin || is_una) && !req_derr;

    sme_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (alu_start),
        .op     (req.req_type),
        .a      (cell_val[1]),
        .b      (cell_val[0]),
        .done   (alu_done),
        .result (alu_res),
        .err    (alu_err)
    );

    assign op_bin = (op_reg.req_type == OP_ADD) || (op_reg.req_type == OP_SUB)
                 || (op_reg.req_type == OP_MUL) || (op_reg.req_type == OP_DIV)
                 || (op_reg.req_type == OP_POW);
    assign op_una = (op_reg.req_type == OP_SQRT) || (op_reg.req_type == OP_SIN)
                 || (op_reg.req_type == OP_COS);
    assign fail   = derr_reg || (used_reg && alu_err);

    assign commit_fire = (state_reg == S_COMMIT) && out_free;

    always_comb
    begin
        top_ctrl  = '0;
        rest_ctrl = '0;
        ins_val   = alu_res;
        new_top   = (count_reg != CW'(0)) ? cell_val[0] : 32'd0;
        count_next = count_reg;
        acc_next   = acc_reg;
        if (commit_fire && !fail && op_reg.req_type != OP_END)
        begin
            if (op_reg.req_type == OP_PUSH)
            begin
                ins_val            = op_reg.push_from_acc ? acc_reg : op_reg.immediate;
                top_ctrl.shift_dn  = 1'b1;
                rest_ctrl.shift_dn = 1'b1;
                new_top            = ins_val;
                count_next         = count_reg + CW'(1);
            end
            else if (op_reg.req_type == OP_POP)
            begin
                top_ctrl.shift_up  = 1'b1;
                rest_ctrl.shift_up = 1'b1;
                new_top            = (count_reg > CW'(1)) ? cell_val[1] : 32'd0;
                count_next         = count_reg - CW'(1);
                if (!op_reg.pop_discard)
                begin
                    acc_next = cell_val[0];
                end
            end
            else if (op_bin)
            begin
                // result replaces the second entry; the rest close up
                top_ctrl.load      = 1'b1;
                rest_ctrl.shift_up = 1'b1;
                new_top            = alu_res;
                count_next         = count_reg - CW'(1);
            end
            else if (op_una)
            begin
                top_ctrl.load = 1'b1;
                new_top       = alu_res;
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign ins_w[gi]  = ins_val;
                assign ctrl_w[gi] = top_ctrl;
            end
            else
            begin : g_body
                assign ins_w[gi]  = cell_val[gi-1];
                assign ctrl_w[gi] = rest_ctrl;
            end
            if (gi == STACK_DEPTH - 1)
            begin : g_tail
                assign blw_w[gi] = 32'd0;
            end
            else
            begin : g_link
                assign blw_w[gi] = cell_val[gi+1];
            end
            sme_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl_w[gi]),
                .ins_val   (ins_w[gi]),
                .below_val (blw_w[gi]),
                .val       (cell_val[gi])
            );
        end
    endgenerate

    assign ext_depth = 32'(count_next);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        derr_next      = derr_reg;
        used_next      = used_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = req;
                    derr_next  = req_derr;
                    used_next  = alu_start;
                    state_next = alu_start ? S_BUSY : S_COMMIT;
                end
            end
            S_BUSY:
            begin
                if (alu_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (out_free)
                begin
                    rsp_next.status     = (op_reg.req_type == OP_END) ? ST_END
                                        : (fail ? ST_ERR : ST_OK);
                    rsp_next.acc_value  = acc_next;
                    rsp_next.top_value  = new_top;
                    rsp_next.depth_used = ext_depth[4:0];
                    rsp_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            acc_reg       <= 32'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            acc_reg       <= acc_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        derr_reg <= derr_next;
        used_reg <= used_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `SME_ASSERT_NXT(a_stall_after_accept, accept, req_stall, "accepted request not held off")
    `SME_ASSERT_NXT(a_count_at_commit, !commit_fire, $stable(count_reg), "depth moved without commit")
    `SME_ASSERT_IMP(a_done_when_busy, alu_done, state_reg == S_BUSY, "alu done outside busy")
    `SME_ASSERT_IMP(a_depth_bound, 1'b1, count_reg <= CW'(STACK_DEPTH), "depth beyond stack")

endmodule

// ----- test/stack_machine_executor_tb.sv -----
module stack_machine_executor_tb;
    import sme_pkg::*;

    localparam int DEPTH = 16;
    localparam int WATCHDOG_LIMIT = 4000;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  req_valid = 1'b0;
    logic  req_stall;
    req_t  req = '0;
    logic  rsp_valid;
    logic  rsp_stall = 1'b0;
    rsp_t  rsp;

    // Shadow copy of the machine state.
    logic [31:0] shadow_stack [DEPTH];
    int unsigned shadow_count;
    logic [31:0] shadow_acc;

    rsp_t expected_rsp_q[$];
    int   error_count;
    int   sent_count;
    int   checked_count;
    int   idle_cycles;
    bit   rsp_stall_enable;
    bit   timed_out;

    stack_machine_executor #(.STACK_DEPTH(DEPTH)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #1 clk = ~clk;

    function automatic logic [31:0] isqrt_of(logic [31:0] v);
        logic [31:0] root;
        logic [31:0] bitv;
        root = 0;
        bitv = 32'h4000_0000;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Returns 0 when the power is undefined.
    function automatic bit power_of(logic [31:0] base, logic [31:0] ex, output logic [31:0] res);
        bit          bneg;
        bit          odd;
        logic [63:0] mag;
        logic [63:0] r;
        logic [31:0] e;
        bneg = base[31];
        odd = ex[0];
        mag = bneg ? {32'd0, 32'd0 - base} : {32'd0, base};
        r = 1;
        res = 0;
        if (ex == 0)
        begin
            res = 1;
            return 1;
        end
        if (ex[31])
        begin
            if (mag == 0)
                return 0;
            if (mag == 1)
                res = (bneg && odd) ? 32'hFFFF_FFFF : 32'd1;
            return 1;
        end
        if (mag == 0)
            return 1;
        e = ex;
        if (mag != 1)
        begin
            while (e > 0 && r <= 64'h8000_0000)
            begin
                r = r * mag;
                if (r > 64'h8000_0000)
                    r = 64'h8000_0001;
                e = e - 1;
            end
        end
        if (bneg && odd)
            res = (r >= 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - r[31:0];
        else
            res = (r > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : r[31:0];
        return 1;
    endfunction

    function automatic rsp_t execute_instr(req_t item);
        rsp_t        out;
        logic [1:0]  status;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        logic [31:0] ma;
        logic [31:0] mb;
        status = ST_OK;
        r = 0;
        case (item.req_type)
            OP_END: status = ST_END;
            OP_PUSH:
                if (shadow_count >= DEPTH)
                    status = ST_ERR;
                else
                begin
                    shadow_stack[shadow_count] = item.push_from_acc ? shadow_acc : item.immediate;
                    shadow_count++;
                end
            OP_POP:
                if (shadow_count == 0)
                    status = ST_ERR;
                else
                begin
                    shadow_count--;
                    if (!item.pop_discard)
                        shadow_acc = shadow_stack[shadow_count];
                end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_POW:
                if (shadow_count < 2)
                    status = ST_ERR;
                else
                begin
                    b = shadow_stack[shadow_count - 1];
                    a = shadow_stack[shadow_count - 2];
                    case (item.req_type)
                        OP_ADD: r = a + b;
                        OP_SUB: r = a - b;
                        OP_MUL: r = a * b;
                        OP_DIV:
                            if (b == 0)
                                status = ST_ERR;
                            else
                            begin
                                ma = a[31] ? 32'd0 - a : a;
                                mb = b[31] ? 32'd0 - b : b;
                                r = ma / mb;
                                if (a[31] != b[31])
                                    r = 32'd0 - r;
                            end
                        default:
                            if (!power_of(a, b, r))
                                status = ST_ERR;
                    endcase
                    if (status == ST_OK)
                    begin
                        shadow_count--;
                        shadow_stack[shadow_count - 1] = r;
                    end
                end
            OP_SQRT, OP_SIN, OP_COS:
                if (shadow_count == 0)
                    status = ST_ERR;
                else
                begin
                    a = shadow_stack[shadow_count - 1];
                    if (item.req_type == OP_SQRT)
                    begin
                        if (a[31])
                            status = ST_ERR;
                        else
                            r = isqrt_of(a);
                    end
                    else if (item.req_type == OP_COS)
                        r = (a == 0) ? 32'd1 : 32'd0;
                    if (status == ST_OK)
                        shadow_stack[shadow_count - 1] = r;
                end
            default: status = ST_ERR;
        endcase
        out.status = status;
        out.acc_value = shadow_acc;
        out.top_value = (shadow_count > 0) ? shadow_stack[shadow_count - 1] : 32'd0;
        out.depth_used = shadow_count[4:0];
        return out;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch on transaction %0d: %s got %h want %h", checked_count, field, got,
            want);
        error_count++;
    endtask

    task automatic send_instr(logic [3:0] op, logic from_acc = 1'b0, logic discard = 1'b0,
        logic [31:0] imm = 32'd0);
        int   gap;
        req_t item;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        // drop valid only when idling before this transaction
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        item.req_type = op;
        item.push_from_acc = from_acc;
        item.pop_discard = discard;
        item.immediate = imm;
        req <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        expected_rsp_q.push_back(execute_instr(item));
        sent_count++;
    endtask

    // Receiver stall: drawn per result.
    initial
    begin
        int wait_cycles;
        forever
        begin
            wait_cycles = rsp_stall_enable ? $urandom_range(0, 6) : 0;
            if (wait_cycles != 0)
            begin
                rsp_stall <= 1'b1;
                repeat (wait_cycles)
                    @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!(rsp_valid && !rsp_stall))
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                $display("unexpected transaction on rsp");
                error_count++;
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch("status", 32'(rsp.status), 32'(want.status));
                if (rsp.acc_value !== want.acc_value)
                    report_mismatch("acc_value", rsp.acc_value, want.acc_value);
                if (rsp.top_value !== want.top_value)
                    report_mismatch("top_value", rsp.top_value, want.top_value);
                if (rsp.depth_used !== want.depth_used)
                    report_mismatch("depth_used", 32'(rsp.depth_used), 32'(want.depth_used));
            end
            checked_count++;
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'd0;
            4: return $urandom_range(0, 20);
            5: return 32'd0 - $urandom_range(0, 20);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_instr(OP_POP);
        send_instr(OP_SQRT);
        send_instr(OP_ADD);
        send_instr(OP_PUSH, 1'b0, 1'b0, 32'h8000_0000);
        send_instr(OP_PUSH, 1'b0, 1'b0, 32'hFFFF_FFFF);
        send_instr(OP_DIV);
        send_instr(OP_PUSH, 1'b0, 1'b0, 32'd0);
        send_instr(OP_DIV);
        send_instr(OP_POW);
        send_instr(OP_PUSH, 1'b0, 1'b0, 32'h7FFF_FFFF);
        send_instr(OP_SQRT);
        send_instr(OP_PUSH, 1'b0, 1'b0, 32'hFFFF_FFFF);
        send_instr(OP_SQRT);
        send_instr(OP_SIN);
        send_instr(OP_COS);
        send_instr(OP_PUSH, 1'b0, 1'b0, 32'd3);
        send_instr(OP_PUSH, 1'b0, 1'b0, 32'd40);
        send_instr(OP_POW);
        send_instr(OP_POP, 1'b0, 1'b0);
        send_instr(OP_PUSH, 1'b1, 1'b0);
        send_instr(OP_END, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_instr(4'hF);
        send_instr(OP_MUL);
        send_instr(OP_SUB);
        send_instr(OP_POP, 1'b0, 1'b1);
    endtask

    task automatic test_overflow();
        repeat (DEPTH + 2)
            send_instr(OP_PUSH, 1'b0, 1'b0, $urandom);
        repeat (DEPTH + 1)
            send_instr(OP_POP, 1'b0, 1'($urandom_range(0, 1)));
    endtask

    task automatic test_random(int count);
        logic [3:0] op;
        repeat (count)
        begin
            // Keep the stack mostly shallow but loaded enough for binary ops.
            if (shadow_count < 2 && $urandom_range(0, 3) != 0)
                op = OP_PUSH;
            else if (shadow_count > 12 && $urandom_range(0, 1) == 0)
                op = OP_POP;
            else if ($urandom_range(0, 15) == 0)
                op = 4'($urandom_range(11, 15));
            else
                op = 4'($urandom_range(0, 10));
            send_instr(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rand_word());
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        req_valid <= 1'b0;
        while (expected_rsp_q.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (60)
            @(posedge clk);
    endtask

    initial
    begin
        error_count = 0;
        sent_count = 0;
        checked_count = 0;
        idle_cycles = 0;
        rsp_stall_enable = 1'b0;
        shadow_count = 0;
        shadow_acc = 0;
        for (int i = 0; i < DEPTH; i++)
            shadow_stack[i] = 0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        rsp_stall_enable = 1'b1;
        test_overflow();
        test_random(200);
        rsp_stall_enable = 1'b0;
        test_random(150);
        rsp_stall_enable = 1'b1;
        test_random(330);
        drain();
        $display("sent %0d instructions, checked %0d results", sent_count, checked_count);
        $display("covered all opcodes, stack limits, divide and power corner cases");
        if (error_count == 0 && expected_rsp_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/sme_pkg.sv
rtl/sme_cell.sv
rtl/sme_alu.sv
rtl/stack_machine_executor.sv
test/stack_machine_executor_tb.sv
